### sv/isrr_pkg.sv
// Package for the inverter serial request responder.
// Holds protocol constants, register indexes and the types shared between modules.
// No dependencies.
`default_nettype none

package isrr_pkg;

   // Request framing
   localparam logic [7:0] REQ_HEADER   = 8'h55;
   localparam logic [3:0] REQ_LAST_IDX = 4'd11;
   localparam logic [7:0] SUM_INIT     = 8'hFF;

   // Reply framing
   localparam logic [7:0] RSP_HEADER   = 8'hA6;
   localparam logic [3:0] RSP_LAST_IDX = 4'd14;

   // Fixed reply contents
   localparam logic [7:0] RSP_TEMP_FIELD  = 8'd100;
   localparam logic [7:0] SET_BYTE7       = 8'd48;
   localparam logic [7:0] SET_BYTE8       = 8'd52;
   localparam logic [7:0] SET_BYTE10      = 8'd244;
   localparam logic [7:0] SET_BYTE12      = 8'd90;
   localparam logic [7:0] SET_BYTE13      = 8'd6;
   localparam logic [3:0] MODE_LOW_STATUS = 4'd1;
   localparam logic [3:0] MODE_LOW_SET    = 4'd3;
   localparam logic [15:0] TEMP_BASE      = 16'd200;

   // Request function codes
   localparam logic [7:0] FN_STATUS_A = 8'd0;
   localparam logic [7:0] FN_STATUS_B = 8'd1;
   localparam logic [7:0] FN_SET_A    = 8'd2;
   localparam logic [7:0] FN_SET_B    = 8'd3;

   // Item kinds carried in tuser
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_TIMEOUT   = 3'd0;
   localparam logic [2:0] CSR_OP_MODE   = 3'd1;
   localparam logic [2:0] CSR_OP_STATUS = 3'd2;
   localparam logic [2:0] CSR_BAT_VOLTS = 3'd3;
   localparam logic [2:0] CSR_BAT_AMPS  = 3'd4;
   localparam logic [2:0] CSR_GRID_VOLTS= 3'd5;
   localparam logic [2:0] CSR_MODEL     = 3'd6;
   localparam logic [2:0] CSR_TYPE      = 3'd7;

   localparam logic [9:0] IDLE_MAX = 10'd1023;

   // Command queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   // Reply register values seen by the back end
   typedef struct packed {
      logic [3:0]  op_mode;
      logic [7:0]  op_status;
      logic [15:0] battery_volts;
      logic [15:0] battery_amps;
      logic [15:0] grid_volts;
      logic [7:0]  model_code;
      logic [7:0]  type_code;
   } reply_cfg_type;

   // One decoded request handed from front to back
   typedef struct packed {
      logic valid;
      logic settings;   // 0: status reply, 1: settings reply
   } req_cmd_type;

endpackage

`default_nettype wire

### sv/isrr_front.sv
// Front end: assembles request frames from received words and ticks.
// Checks header, checksum and function code and posts a reply command. Uses isrr_pkg.
`default_nettype none

module isrr_front import isrr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic        kind,
   input  wire logic [7:0]  rx_byte,
   input  wire logic [9:0]  timeout_ms,
   output req_cmd_type      cmd
);

   logic [3:0] count_ff, count_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] func_ff, func_in;
   logic [7:0] sum_ff, sum_in;
   logic [9:0] idle_ff, idle_in;
   logic [9:0] idle_inc;
   logic       known_fn;

   assign idle_inc = (idle_ff < IDLE_MAX) ? idle_ff + 10'd1 : idle_ff;
   assign known_fn = (func_ff == FN_STATUS_A) || (func_ff == FN_STATUS_B) ||
                     (func_ff == FN_SET_A) || (func_ff == FN_SET_B);

   always_comb begin
      count_in     = count_ff;
      first_in     = first_ff;
      func_in      = func_ff;
      sum_in       = sum_ff;
      idle_in      = idle_ff;
      cmd.valid    = 1'b0;
      cmd.settings = func_ff[1];
      if (accept) begin
         if (kind == KIND_TICK) begin
            if (idle_inc > timeout_ms) begin
               count_in = 4'd0;
               sum_in   = SUM_INIT;
               idle_in  = 10'd0;
            end else begin
               idle_in = idle_inc;
            end
         end else if (count_ff == 4'd0) begin
            first_in = rx_byte;
            count_in = 4'd1;
            idle_in  = 10'd0;
         end else if (first_ff != REQ_HEADER) begin
            count_in = 4'd0;
            sum_in   = SUM_INIT;
         end else if (count_ff < REQ_LAST_IDX) begin
            if (count_ff == 4'd1) begin
               func_in = rx_byte;
            end
            sum_in   = sum_ff - rx_byte;
            count_in = count_ff + 4'd1;
            idle_in  = 10'd0;
         end else begin
            count_in  = 4'd0;
            sum_in    = SUM_INIT;
            cmd.valid = (sum_ff == rx_byte) && known_fn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
         first_ff <= 8'd0;
         sum_ff   <= SUM_INIT;
         idle_ff  <= 10'd0;
      end else begin
         count_ff <= count_in;
         first_ff <= first_in;
         sum_ff   <= sum_in;
         idle_ff  <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
   end

endmodule

`default_nettype wire

### sv/isrr_queue.sv
// Short command queue between the frame parser and the reply sequencer.
// Uses isrr_pkg for its depth.
`default_nettype none

module isrr_queue import isrr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire logic push_settings,
   input  wire logic pop,
   output logic      pop_settings,
   output logic      empty,
   output logic      full
);

   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   level_ff, level_in;
   logic              slot_ff [QDEPTH];

   assign empty        = (level_ff == '0);
   assign full         = (level_ff == (QPTR_W+1)'(QDEPTH));
   assign pop_settings = slot_ff[rd_ptr_ff];

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_settings;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("command queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("command queue underflow");
   a_ptr_level: assert property (@(posedge clock) disable iff (reset)
      (level_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

### sv/isrr_back.sv
// Back end: sequences the fifteen reply words and computes the reply checksum.
// Owns the temperature cycle and the output register. Uses isrr_pkg.
`default_nettype none

module isrr_back import isrr_pkg::*; #(
   parameter int TEMP_STEPS = 80
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire reply_cfg_type cfg,
   input  wire logic          q_empty,
   input  wire logic          q_settings,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);

   localparam int TSW = $clog2(TEMP_STEPS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [3:0]     idx_ff, idx_in;
   logic           settings_ff, settings_in;
   logic [7:0]     sum_ff, sum_in;
   logic [TSW-1:0] step_ff, step_in;
   logic           valid_ff, valid_in;
   logic [7:0]     data_ff;
   logic           last_ff;
   logic           load;
   logic [7:0]     cur_byte;
   logic [15:0]    temp;

   // step*10 + 200 as two shifted adds
   assign temp = {{(13-TSW){1'b0}}, step_ff, 3'b000} +
                 {{(15-TSW){1'b0}}, step_ff, 1'b0} + TEMP_BASE;

   assign load  = (state_ff == ST_SEND) && (!valid_ff || rsp_tready);
   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      case (idx_ff)
         4'd0:    cur_byte = RSP_HEADER;
         4'd3:    cur_byte = {cfg.op_mode, settings_ff ? MODE_LOW_SET : MODE_LOW_STATUS};
         4'd4:    cur_byte = cfg.op_status;
         4'd5:    cur_byte = settings_ff ? cfg.model_code : cfg.battery_volts[15:8];
         4'd6:    cur_byte = settings_ff ? cfg.type_code  : cfg.battery_volts[7:0];
         4'd7:    cur_byte = settings_ff ? SET_BYTE7      : cfg.battery_amps[15:8];
         4'd8:    cur_byte = settings_ff ? SET_BYTE8      : cfg.battery_amps[7:0];
         4'd9:    cur_byte = settings_ff ? 8'd0           : cfg.grid_volts[15:8];
         4'd10:   cur_byte = settings_ff ? SET_BYTE10     : cfg.grid_volts[7:0];
         4'd11:   cur_byte = RSP_TEMP_FIELD;
         4'd12:   cur_byte = settings_ff ? SET_BYTE12     : temp[15:8];
         4'd13:   cur_byte = settings_ff ? SET_BYTE13     : temp[7:0];
         4'd14:   cur_byte = sum_ff;
         default: cur_byte = 8'd0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      settings_in = settings_ff;
      sum_in      = sum_ff;
      step_in     = step_ff;
      valid_in    = valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               settings_in = q_settings;
               idx_in      = 4'd0;
               state_in    = ST_SEND;
            end
         end
         ST_SEND: begin
            if (load) begin
               valid_in = 1'b1;
               if (idx_ff == 4'd0) begin
                  sum_in = SUM_INIT;
               end else begin
                  sum_in = sum_ff - cur_byte;
               end
               idx_in = idx_ff + 4'd1;
               if (idx_ff == RSP_LAST_IDX) begin
                  state_in = ST_IDLE;
                  if (!settings_ff) begin
                     step_in = (step_ff == TSW'(TEMP_STEPS - 1)) ? '0 : step_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      settings_ff <= settings_in;
      sum_ff      <= sum_in;
      if (load) begin
         data_ff <= cur_byte;
         last_ff <= (idx_ff == RSP_LAST_IDX);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   a_last_ends_reply: assert property (@(posedge clock) disable iff (reset)
      (load && idx_ff == RSP_LAST_IDX) |=> (state_ff == ST_IDLE))
      else $error("reply did not end after its checksum word");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_SEND && idx_ff == 4'd0))
      else $error("popped command did not start a reply");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (idx_ff <= RSP_LAST_IDX))
      else $error("reply word index out of range");

endmodule

`default_nettype wire

### sv/inverter_serial_request_responder.sv
// Top level of the inverter serial request responder.
// Holds the configuration registers and joins front end, command queue and back end.
// Depends on isrr_pkg, isrr_front, isrr_queue and isrr_back.
`default_nettype none

// The block takes one input word per clock cycle, a received serial byte or a
// one millisecond tick, and is ready whenever its four-entry command queue has
// room; a stalled reply only holds req_tready low once four complete requests
// are waiting behind it. With the back end idle, the twelfth byte of an answerable
// request posts a command to the queue; the back end pops it, enters its send state
// and loads the first reply word into its output register. It then issues one
// reply word per cycle while rsp_tready stays high, fifteen words per reply,
// and returns to idle between replies to take the next command, so the reply
// channel sets the sustained rate of answered requests. Configuration writes
// are accepted every cycle and should only be made while no reply is pending.

module inverter_serial_request_responder import isrr_pkg::*; #(
   parameter int TEMP_STEPS = 80
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] func: 0 received byte, 1 tick
   // Reply stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] tx_byte
   output logic             rsp_tlast,
   // Configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic [9:0]    timeout_ff;
   reply_cfg_type cfg_ff;
   req_cmd_type   cmd;
   logic          q_pop, q_settings, q_empty, q_full;
   logic          accept;

   // Registers are always writable.
   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff           <= 10'd50;
         cfg_ff.op_mode       <= 4'd9;
         cfg_ff.op_status     <= 8'd0;
         cfg_ff.battery_volts <= 16'd535;
         cfg_ff.battery_amps  <= 16'd100;
         cfg_ff.grid_volts    <= 16'd250;
         cfg_ff.model_code    <= 8'd212;
         cfg_ff.type_code     <= 8'd48;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TIMEOUT:    timeout_ff           <= csr_data[9:0];
            CSR_OP_MODE:    cfg_ff.op_mode       <= csr_data[3:0];
            CSR_OP_STATUS:  cfg_ff.op_status     <= csr_data[7:0];
            CSR_BAT_VOLTS:  cfg_ff.battery_volts <= csr_data;
            CSR_BAT_AMPS:   cfg_ff.battery_amps  <= csr_data;
            CSR_GRID_VOLTS: cfg_ff.grid_volts    <= csr_data;
            CSR_MODEL:      cfg_ff.model_code    <= csr_data[7:0];
            CSR_TYPE:       cfg_ff.type_code     <= csr_data[7:0];
            default:        timeout_ff           <= timeout_ff;
         endcase
      end
   end

   // Parser: one word per cycle while the queue has room; posts answerable requests.
   isrr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_tuser),
      .rx_byte    (req_tdata),
      .timeout_ms (timeout_ff),
      .cmd        (cmd)
   );

   // Decouples parsing from the reply stream.
   isrr_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .push          (cmd.valid),
      .push_settings (cmd.settings),
      .pop           (q_pop),
      .pop_settings  (q_settings),
      .empty         (q_empty),
      .full          (q_full)
   );

   // Reply sequencer with its own output register.
   isrr_back #(
      .TEMP_STEPS (TEMP_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_settings (q_settings),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the inverter serial request responder.
// Sends request bytes and tick words, predicts the status and settings replies,
// and checks every reply word as it arrives. Depends on isrr_pkg and the responder RTL.
`timescale 1ns / 100ps

module tb_top import isrr_pkg::*;;

   // Protocol values, written down independently of the design package.
   localparam int          TEMP_CYCLE   = 80;
   localparam int          REPLY_WORDS  = 15;
   localparam int          REQ_LAST     = 11;     // index of the request checksum byte
   localparam logic [7:0]  REQ_SYNC     = 8'h55;
   localparam logic [7:0]  REPLY_SYNC   = 8'hA6;
   localparam logic [7:0]  SUM_START    = 8'hFF;
   localparam logic [9:0]  TICKS_TOP    = 10'd1023;
   localparam logic [15:0] TEMP_OFFSET  = 16'd200;
   localparam logic [15:0] TEMP_STRIDE  = 16'd10;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          DRAIN_LIMIT  = 20000;

   // Where the expected reply of a directed row comes from: the predictor, or
   // one of the two replies that can be read straight off the reset values.
   typedef enum logic [1:0] {FROM_MODEL, RESET_STATUS, RESET_SETTINGS} reply_src_type;

   typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_SHORT, FRAME_BAD_HEADER,
                 FRAME_NOISE} frame_kind_type;

   typedef struct packed {
      logic          kind;
      reply_src_type src;
      logic [7:0]    octet;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] octet;
      logic       last;
   } reply_word_type;

   // Reset register values: mode 9, status 0, 535, 100, 250, model 212, type 48.
   localparam logic [0:14][7:0] RESET_STATUS_REPLY = {
      8'hA6, 8'h00, 8'h00, 8'h91, 8'h00, 8'h02, 8'h17, 8'h00,
      8'h64, 8'h00, 8'hFA, 8'h64, 8'h00, 8'hC8, 8'hCB
   };
   localparam logic [0:14][7:0] RESET_SETTINGS_REPLY = {
      8'hA6, 8'h00, 8'h00, 8'h93, 8'h00, 8'hD4, 8'h30, 8'h30,
      8'h34, 8'h00, 8'hF4, 8'h64, 8'h5A, 8'h06, 8'h4C
   };

   // Directed stimulus, run straight after reset with the reset register values.
   localparam int N_DIRECTED = 27;
   localparam stim_row_type [0:N_DIRECTED-1] DIRECTED = {
      // A tick on an empty buffer; the data bits of a tick must be ignored.
      {KIND_TICK, FROM_MODEL, 8'hFF},
      // A first byte that is not the header is kept unchecked, then the next
      // byte throws the whole buffer away.
      {KIND_BYTE, FROM_MODEL, 8'h00},
      {KIND_BYTE, FROM_MODEL, 8'hFF},
      // Status request with an all-zero body, so its checksum is 0xFF.
      {KIND_BYTE, FROM_MODEL, REQ_SYNC},
      {KIND_BYTE, FROM_MODEL, FN_STATUS_A},
      {9{KIND_BYTE, FROM_MODEL, 8'h00}},
      {KIND_BYTE, RESET_STATUS, 8'hFF},
      // Settings request with an all-ones body; the checksum wraps round to 0x05.
      {KIND_BYTE, FROM_MODEL, REQ_SYNC},
      {KIND_BYTE, FROM_MODEL, FN_SET_B},
      {9{KIND_BYTE, FROM_MODEL, 8'hFF}},
      {KIND_BYTE, RESET_SETTINGS, 8'h05}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [15:0] csr_data = 16'd0;

   inverter_serial_request_responder #(
      .TEMP_STEPS(TEMP_CYCLE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A generous upper bound; a correct run needs a small fraction of this.
   initial begin
      #5_000_000;
      $display("Timed out waiting for the responder.");
      $display("FAIL");
      $finish;
   end

   // Shadow copy of the registers, held at their reset values until written.
   logic [9:0]  cfg_timeout = 10'd50;
   logic [3:0]  cfg_mode    = 4'd9;
   logic [7:0]  cfg_status  = 8'd0;
   logic [15:0] cfg_bat_v   = 16'd535;
   logic [15:0] cfg_bat_a   = 16'd100;
   logic [15:0] cfg_grid    = 16'd250;
   logic [7:0]  cfg_model   = 8'd212;
   logic [7:0]  cfg_type    = 8'd48;

   // Shadow copy of the request collector and the temperature cycle.
   logic [3:0]  rq_count   = 4'd0;
   logic [7:0]  rq_head    = 8'd0;
   logic [7:0]  rq_func    = 8'd0;
   logic [7:0]  rq_sum     = SUM_START;
   logic [9:0]  idle_ticks = 10'd0;
   logic [6:0]  temp_pos   = 7'd0;

   logic [7:0]  reply_frame [REPLY_WORDS];
   reply_word_type expected_words [$];

   bit idling_on = 1'b1;
   int words_sent = 0;
   int reply_words = 0;
   int replies = 0;
   int mismatches = 0;

   // Works out what one accepted word does to the collector. When it completes
   // a request that must be answered, the reply lands in reply_frame.
   task automatic predict_responder(input logic kind, input logic [7:0] rx,
                                    output int n_words);
      logic [15:0] temp;
      logic [7:0]  sum;
      logic        sum_ok;
      n_words = 0;
      if (kind == KIND_TICK) begin
         if (idle_ticks != TICKS_TOP)
            idle_ticks++;
         // The timeout fires even when nothing is buffered.
         if (idle_ticks > cfg_timeout) begin
            rq_count = 4'd0;
            rq_sum = SUM_START;
            idle_ticks = 10'd0;
         end
      end else if (rq_count == 4'd0) begin
         rq_head = rx;
         rq_count = 4'd1;
         idle_ticks = 10'd0;
      end else if (rq_head != REQ_SYNC) begin
         // Bad header: the new byte goes too, and the idle count is kept.
         rq_count = 4'd0;
         rq_sum = SUM_START;
      end else if (rq_count < REQ_LAST) begin
         if (rq_count == 4'd1)
            rq_func = rx;
         rq_sum = rq_sum - rx;
         rq_count++;
         idle_ticks = 10'd0;
      end else begin
         sum_ok = (rq_sum == rx);
         rq_count = 4'd0;
         rq_sum = SUM_START;
         if (sum_ok && rq_func <= FN_SET_B) begin
            reply_frame[0] = REPLY_SYNC;
            reply_frame[1] = 8'd0;
            reply_frame[2] = 8'd0;
            reply_frame[4] = cfg_status;
            reply_frame[11] = 8'd100;
            if (rq_func == FN_STATUS_A || rq_func == FN_STATUS_B) begin
               temp = temp_pos * TEMP_STRIDE + TEMP_OFFSET;
               reply_frame[3] = {cfg_mode, 4'd1};
               reply_frame[5] = cfg_bat_v[15:8];
               reply_frame[6] = cfg_bat_v[7:0];
               reply_frame[7] = cfg_bat_a[15:8];
               reply_frame[8] = cfg_bat_a[7:0];
               reply_frame[9] = cfg_grid[15:8];
               reply_frame[10] = cfg_grid[7:0];
               reply_frame[12] = temp[15:8];
               reply_frame[13] = temp[7:0];
               temp_pos = (temp_pos + 1 >= TEMP_CYCLE) ? 7'd0 : temp_pos + 7'd1;
            end else begin
               reply_frame[3] = {cfg_mode, 4'd3};
               reply_frame[5] = cfg_model;
               reply_frame[6] = cfg_type;
               reply_frame[7] = 8'd48;
               reply_frame[8] = 8'd52;
               reply_frame[9] = 8'd0;
               reply_frame[10] = 8'd244;
               reply_frame[12] = 8'd90;
               reply_frame[13] = 8'd6;
            end
            sum = SUM_START;
            for (int i = 1; i < REPLY_WORDS - 1; i++)
               sum = sum - reply_frame[i];
            reply_frame[REPLY_WORDS-1] = sum;
            n_words = REPLY_WORDS;
         end
      end
   endtask

   // Offers one word on the request side, optionally after a short gap, and
   // queues whatever reply it must cause once the responder has taken it.
   task automatic send_item(input logic kind, input logic [7:0] octet,
                            input reply_src_type src);
      reply_word_type w;
      int n_words;
      if (idling_on && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= octet;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      predict_responder(kind, octet, n_words);
      for (int i = 0; i < n_words; i++) begin
         case (src)
            RESET_STATUS:   w.octet = RESET_STATUS_REPLY[i];
            RESET_SETTINGS: w.octet = RESET_SETTINGS_REPLY[i];
            default:        w.octet = reply_frame[i];
         endcase
         w.last = (i == REPLY_WORDS - 1);
         expected_words = {expected_words, w};
      end
   endtask

   // Sends one request-shaped sequence. Truncated requests are either timed out
   // or padded to twelve bytes, so that later requests stay in step.
   task automatic send_frame(input frame_kind_type flavour);
      logic [7:0] fn;
      logic [7:0] sum;
      logic [7:0] octet;
      int keep;
      int hold;
      case (flavour)
         FRAME_NOISE: begin
            repeat ($urandom_range(1, 4))
               send_item(KIND_TICK, 8'($urandom), FROM_MODEL);
         end
         FRAME_BAD_HEADER: begin
            do octet = 8'($urandom); while (octet == REQ_SYNC);
            send_item(KIND_BYTE, octet, FROM_MODEL);
            send_item(KIND_BYTE, 8'($urandom), FROM_MODEL);
         end
         default: begin
            if ($urandom_range(0, 4) != 0)
               fn = 8'($urandom_range(0, 3));
            else
               fn = 8'($urandom_range(4, 255));
            keep = (flavour == FRAME_SHORT) ? $urandom_range(1, REQ_LAST) : REQ_LAST + 1;
            sum = SUM_START;
            send_item(KIND_BYTE, REQ_SYNC, FROM_MODEL);
            for (int i = 1; i < keep; i++) begin
               if (i == REQ_LAST)
                  octet = (flavour == FRAME_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
               else if (i == 1)
                  octet = fn;
               else
                  octet = 8'($urandom);
               sum = sum - octet;
               // A lone tick after a kept byte never reaches the timeout.
               if ($urandom_range(0, 19) == 0)
                  send_item(KIND_TICK, 8'($urandom), FROM_MODEL);
               send_item(KIND_BYTE, octet, FROM_MODEL);
            end
            if (flavour == FRAME_SHORT) begin
               if (cfg_timeout <= 60 && $urandom_range(0, 3) != 0) begin
                  repeat (cfg_timeout + 1)
                     send_item(KIND_TICK, 8'($urandom), FROM_MODEL);
               end else begin
                  hold = $urandom_range(0, (cfg_timeout > 60) ? 60 : cfg_timeout);
                  repeat (hold)
                     send_item(KIND_TICK, 8'($urandom), FROM_MODEL);
                  repeat (REQ_LAST + 1 - keep)
                     send_item(KIND_BYTE, 8'($urandom), FROM_MODEL);
               end
            end
         end
      endcase
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TIMEOUT:    cfg_timeout = value[9:0];
         CSR_OP_MODE:    cfg_mode = value[3:0];
         CSR_OP_STATUS:  cfg_status = value[7:0];
         CSR_BAT_VOLTS:  cfg_bat_v = value;
         CSR_BAT_AMPS:   cfg_bat_a = value;
         CSR_GRID_VOLTS: cfg_grid = value;
         CSR_MODEL:      cfg_model = value[7:0];
         default:        cfg_type = value[7:0];
      endcase
   endtask

   function automatic logic [15:0] register_top(input int idx);
      case (idx)
         CSR_TIMEOUT:    return 16'd1000;
         CSR_OP_MODE:    return 16'd15;
         CSR_OP_STATUS,
         CSR_MODEL,
         CSR_TYPE:       return 16'd255;
         default:        return 16'hFFFF;
      endcase
   endfunction

   // Setting 0 puts every register at its floor, setting 1 at its ceiling; the
   // later ones draw random values, with a short and then the reset timeout.
   task automatic program_setting(input int setting);
      logic [15:0] value;
      for (int r = 0; r < 8; r++) begin
         case (setting)
            0:       value = (r == CSR_TIMEOUT) ? 16'd1 : 16'd0;
            1:       value = register_top(r);
            default: value = 16'($urandom_range(0, register_top(r)));
         endcase
         if (r == CSR_TIMEOUT && setting == 2)
            value = 16'($urandom_range(2, 40));
         if (r == CSR_TIMEOUT && setting == 3)
            value = 16'd50;
         write_register(3'(r), value);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Holds the request side quiet until every expected reply word has come or the
   // limit runs out, then lets the pipeline settle to finish any word without one.
   task automatic drain_replies(input int limit);
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%t: %s", $realtime, what);
   endtask

   // The reply side stalls at random, in bursts, while idling is on.
   always @(negedge clock) begin
      int hold;
      if (!idling_on) begin
         rsp_tready <= 1'b1;
      end else if (hold > 0) begin
         rsp_tready <= 1'b0;
         hold--;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         hold = $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every reply word taken is compared, field by field, with the oldest one
   // still expected.
   always @(posedge clock) begin
      reply_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         reply_words++;
         if (rsp_tlast)
            replies++;
         if (expected_words.size() == 0) begin
            note_mismatch($sformatf("unexpected reply word: tdata %02h tlast %0b",
                                    rsp_tdata, rsp_tlast));
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata !== want.octet || rsp_tlast !== want.last)
               note_mismatch($sformatf(
                  "reply word %0d: expected tdata %02h tlast %0b, got tdata %02h tlast %0b",
                  reply_words, want.octet, want.last, rsp_tdata, rsp_tlast));
         end
      end
   end

   initial begin
      stim_row_type row;
      frame_kind_type flavour;
      int pick;
      int phase_end;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed table first, with the registers still at their reset values.
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = DIRECTED[i];
         send_item(row.kind, row.octet, row.src);
      end

      // Then four register settings, each followed by mostly well-formed
      // requests with random content, mixed with broken ones and noise. The
      // last setting runs with no idling on either side.
      for (int setting = 0; setting < 4; setting++) begin
         drain_replies(DRAIN_LIMIT);
         program_setting(setting);
         idling_on = (setting != 3);
         phase_end = words_sent + 50;
         while (words_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
               flavour = FRAME_GOOD;
            else if (pick < 65)
               flavour = FRAME_BAD_SUM;
            else if (pick < 80)
               flavour = FRAME_SHORT;
            else if (pick < 90)
               flavour = FRAME_BAD_HEADER;
            else
               flavour = FRAME_NOISE;
            send_frame(flavour);
         end
      end

      drain_replies(DRAIN_LIMIT);
      if (expected_words.size() != 0)
         note_mismatch($sformatf("%0d reply words never arrived", expected_words.size()));

      $display("Sent %0d request-side words, %0d of them from the directed table,",
               words_sent, N_DIRECTED);
      $display("under four register settings; checked %0d reply words in %0d replies.",
               reply_words, replies);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches in total.", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
